@@ src/dual_bank_charge_sequencer_core_assert.svh @@
// Assertion helpers for the charge sequencer core.
`ifndef DUAL_BANK_CHARGE_SEQUENCER_CORE_ASSERT_SVH
`define DUAL_BANK_CHARGE_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication.
`define DBCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DBCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/dbcs_pkg.sv @@
package dbcs_pkg;

    localparam int TIMER_BITS = 16;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_CHG1 = 3'd1,
        PH_CHG2 = 3'd2,
        PH_TRK1 = 3'd3,
        PH_TRK2 = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_OFF   = 2'd0,
        ST_BANK1 = 2'd1,
        ST_BANK2 = 2'd2,
        ST_DONE  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CFG_DONE_DETECT  = 3'd0,
        CFG_DONE_EXPIRE  = 3'd1,
        CFG_TRICKLE      = 3'd2,
        CFG_PAUSE        = 3'd3,
        CFG_TRK_THRESH   = 3'd4,
        CFG_DEBOUNCE     = 3'd5,
        CFG_GRACE        = 3'd6,
        CFG_STUCK_LIMIT  = 3'd7
    } t_cfg_idx;

    // relay drive: bit0 bank1, bit1 bank2, bit2 common
    localparam logic [2:0] RELAY_OFF   = 3'b000;
    localparam logic [2:0] RELAY_BANK1 = 3'b101;
    localparam logic [2:0] RELAY_BANK2 = 3'b110;

    localparam logic [15:0] DETECT_RESET   = 16'd700;
    localparam logic [15:0] EXPIRE_RESET   = 16'd40000;
    localparam logic [15:0] TRICKLE_RESET  = 16'd60000;
    localparam logic [15:0] PAUSE_RESET    = 16'd10000;
    localparam logic [15:0] THRESH_RESET   = 16'd50000;
    localparam logic [7:0]  DEBOUNCE_RESET = 8'd100;
    localparam logic [7:0]  GRACE_RESET    = 8'd130;
    localparam logic [15:0] STUCK_RESET    = 16'd1000;

    typedef struct packed {
        t_phase      phase;
        logic        relay_bank1;
        logic        relay_bank2;
        logic        relay_common;
        t_status     status_lines;
        logic        timekeeping_on;
        logic        force_reset;
        logic [7:0]  report_flags;
    } t_result;

endpackage

@@ src/dbcs_in_if.sv @@
interface dbcs_in_if;
    logic valid;
    logic ready;
    logic kind;
    logic psu_absent;
    logic charger1_busy;
    logic charger2_busy;
    logic charger3_busy;
    logic three_battery_jumper;

    modport source (
        output valid, kind, psu_absent, charger1_busy, charger2_busy, charger3_busy,
               three_battery_jumper,
        input  ready
    );
    modport sink (
        input  valid, kind, psu_absent, charger1_busy, charger2_busy, charger3_busy,
               three_battery_jumper,
        output ready
    );
endinterface

@@ src/dbcs_out_if.sv @@
interface dbcs_out_if import dbcs_pkg::*; ;
    logic        valid;
    logic        ready;
    t_phase      phase;
    logic        relay_bank1;
    logic        relay_bank2;
    logic        relay_common;
    t_status     status_lines;
    logic        timekeeping_on;
    logic        force_reset;
    logic [7:0]  report_flags;

    modport source (
        output valid, phase, relay_bank1, relay_bank2, relay_common, status_lines,
               timekeeping_on, force_reset, report_flags,
        input  ready
    );
    modport sink (
        input  valid, phase, relay_bank1, relay_bank2, relay_common, status_lines,
               timekeeping_on, force_reset, report_flags,
        output ready
    );
endinterface

@@ src/dual_bank_charge_sequencer_core.sv @@
// The result of a request is registered and is on o_result in the cycle after it is accepted.
// Throughput: one request per cycle; the single result register is refilled in the
//   cycle it is taken, so i_item.ready only drops while a result waits unread.
// Reset: synchronous on i_rst_n low; state, result valid and config registers go
//   to their defaults. No clearing pass, the block is ready the cycle after reset.
module dual_bank_charge_sequencer_core import dbcs_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dbcs_in_if.sink         i_item,
    dbcs_out_if.source      o_result,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [15:0]     i_cfg_data
);

    localparam int TW = TIMER_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] r_cfg_detect, r_cfg_expire, r_cfg_trickle, r_cfg_pause;
    logic [15:0] r_cfg_thresh, r_cfg_stuck;
    logic [7:0]  r_cfg_debounce, r_cfg_grace;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_detect   <= DETECT_RESET;
            r_cfg_expire   <= EXPIRE_RESET;
            r_cfg_trickle  <= TRICKLE_RESET;
            r_cfg_pause    <= PAUSE_RESET;
            r_cfg_thresh   <= THRESH_RESET;
            r_cfg_debounce <= DEBOUNCE_RESET;
            r_cfg_grace    <= GRACE_RESET;
            r_cfg_stuck    <= STUCK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DONE_DETECT: r_cfg_detect   <= i_cfg_data;
                CFG_DONE_EXPIRE: r_cfg_expire   <= i_cfg_data;
                CFG_TRICKLE:     r_cfg_trickle  <= i_cfg_data;
                CFG_PAUSE:       r_cfg_pause    <= i_cfg_data;
                CFG_TRK_THRESH:  r_cfg_thresh   <= i_cfg_data;
                CFG_DEBOUNCE:    r_cfg_debounce <= i_cfg_data[7:0];
                CFG_GRACE:       r_cfg_grace    <= i_cfg_data[7:0];
                CFG_STUCK_LIMIT: r_cfg_stuck    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    t_phase          r_phase, n_phase;
    logic            r_three_mode, n_three_mode;
    logic [2:0]      r_relay, n_relay;
    t_status         r_status, n_status;
    logic [TW-1:0]   r_trickle, n_trickle;
    logic [7:0]      r_debounce, n_debounce;
    logic [7:0]      r_grace, n_grace;
    logic            r_tick_en, n_tick_en;
    logic [2:0]      r_done, n_done;
    logic [2:0]      r_pend, n_pend;
    logic [TW-1:0]   r_chg_tmr [3];
    logic [TW-1:0]   n_chg_tmr [3];
    logic [TW-1:0]   r_connect, n_connect;
    logic [TW-1:0]   r_stuck, n_stuck;
    logic            r_last_absent, n_last_absent;

    // Result register (output side of the pipe)
    logic            r_out_valid;
    t_result         r_out, n_out;

    // Handshake: a new request is taken whenever the result slot is free or
    // is being emptied in this same cycle.
    logic w_in_acc;
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign w_in_acc     = i_item.valid && i_item.ready;

    logic          w_poll, w_tick, w_forced, w_active;
    logic [TW-1:0] w_stuck_dec;
    logic [2:0]    w_busy;

    assign w_poll      = w_in_acc && i_item.kind;
    // ticks only count while timekeeping is on; otherwise they are no-ops
    assign w_tick      = w_in_acc && !i_item.kind && r_tick_en;
    assign w_stuck_dec = r_stuck - TW'(1);
    // stuck counter ran out: whole sequencer falls back to its reset state
    assign w_forced    = w_tick && (w_stuck_dec == '0);
    assign w_busy      = {i_item.charger3_busy, i_item.charger2_busy, i_item.charger1_busy};

    // Phase codes outside the defined set behave like idle.
    always_comb begin
        case (r_phase)
            PH_CHG1, PH_CHG2, PH_TRK1, PH_TRK2: w_active = 1'b1;
            default:                            w_active = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Per-charger done detector: pending -> confirmed, with a detect timer
    // while pending and an expiry timer once confirmed.
    // ------------------------------------------------------------------
    logic [2:0]    dd_done, dd_pend;
    logic [TW-1:0] dd_tmr [3];
    logic          dd_all;

    always_comb begin
        dd_done = r_done;
        dd_pend = r_pend;
        dd_tmr  = r_chg_tmr;
        for (int k = 0; k < 3; k++) begin
            if (w_busy[k]) begin
                // confirmed mark only dies once its expiry ran out
                if (r_done[k] && (r_chg_tmr[k] == '0)) dd_done[k] = 1'b0;
                if (r_pend[k]) begin
                    dd_pend[k] = 1'b0;
                    dd_tmr[k]  = '0;
                end
            end else if (r_done[k]) begin
                dd_tmr[k] = TW'(r_cfg_expire);
            end else if (r_pend[k]) begin
                if (r_chg_tmr[k] == '0) begin
                    dd_pend[k] = 1'b0;
                    dd_done[k] = 1'b1;
                    dd_tmr[k]  = TW'(r_cfg_expire);
                end
            end else begin
                dd_pend[k] = 1'b1;
                dd_tmr[k]  = TW'(r_cfg_detect);
            end
        end
        // five-battery mode: first bank is finished when chargers two and three are
        if (r_phase == PH_CHG1 && !r_three_mode) dd_all = dd_done[2] && dd_done[1];
        else                                     dd_all = &dd_done;
    end

    // Phase exit condition; taking it clears the detector and reloads the
    // trickle timer.
    logic w_adv;
    always_comb begin
        case (r_phase)
            PH_CHG1:          w_adv = dd_all;
            PH_CHG2:          w_adv = dd_all && !r_three_mode;
            PH_TRK1, PH_TRK2: w_adv = dd_all && (r_trickle == '0);
            default:          w_adv = 1'b0;
        endcase
    end

    logic w_present_start;  // supply present and debounced in idle: start charging
    assign w_present_start = !i_item.psu_absent && (r_debounce == '0);

    // ------------------------------------------------------------------
    // Next phase
    // ------------------------------------------------------------------
    always_comb begin
        n_phase = r_phase;
        if (w_forced) begin
            n_phase = PH_IDLE;
        end else if (w_poll) begin
            if (w_active && i_item.psu_absent) begin
                n_phase = PH_IDLE;
            end else begin
                case (r_phase)
                    PH_CHG1: if (w_adv) n_phase = r_three_mode ? PH_TRK1 : PH_CHG2;
                    PH_CHG2: if (w_adv) n_phase = PH_TRK1;
                    PH_TRK1: if (w_adv) n_phase = r_three_mode ? PH_TRK1 : PH_TRK2;
                    PH_TRK2: if (w_adv) n_phase = PH_TRK1;
                    default: n_phase = w_present_start ? PH_CHG1 : PH_IDLE;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Drive and timers
    // ------------------------------------------------------------------
    always_comb begin
        n_three_mode  = r_three_mode;
        n_relay       = r_relay;
        n_status      = r_status;
        n_trickle     = r_trickle;
        n_debounce    = r_debounce;
        n_grace       = r_grace;
        n_tick_en     = r_tick_en;
        n_done        = r_done;
        n_pend        = r_pend;
        n_chg_tmr     = r_chg_tmr;
        n_connect     = r_connect;
        n_stuck       = r_stuck;
        n_last_absent = r_last_absent;

        if (w_forced) begin
            n_three_mode  = 1'b1;
            n_relay       = RELAY_OFF;
            n_status      = ST_OFF;
            n_trickle     = '0;
            n_debounce    = DEBOUNCE_RESET;
            n_grace       = '0;
            n_tick_en     = 1'b0;
            n_done        = '0;
            n_pend        = '0;
            n_chg_tmr     = '{default: '0};
            n_connect     = '0;
            n_stuck       = TW'(r_cfg_stuck);
            n_last_absent = 1'b1;
        end else if (w_tick) begin
            n_stuck = w_stuck_dec;
            if (r_trickle != '0)  n_trickle  = r_trickle - TW'(1);
            if (r_debounce != '0) n_debounce = r_debounce - 8'd1;
            if (!w_active && r_grace != '0) n_grace = r_grace - 8'd1;
            for (int k = 0; k < 3; k++)
                if (r_chg_tmr[k] != '0) n_chg_tmr[k] = r_chg_tmr[k] - TW'(1);
            if (r_connect != '0)  n_connect  = r_connect - TW'(1);
        end else if (w_poll) begin
            n_stuck       = TW'(r_cfg_stuck);
            n_last_absent = i_item.psu_absent;

            if (w_active) begin
                if (i_item.psu_absent) begin
                    if (r_tick_en && r_grace == '0) n_tick_en = 1'b0;
                end else if (w_adv) begin
                    n_done    = '0;
                    n_pend    = '0;
                    n_chg_tmr = '{default: '0};
                    // five-battery hand-over to bank 2 starts with a pause
                    n_trickle = (r_phase == PH_CHG1 && !r_three_mode) ?
                                TW'(r_cfg_pause) : TW'(r_cfg_trickle);
                end else begin
                    n_done    = dd_done;
                    n_pend    = dd_pend;
                    n_chg_tmr = dd_tmr;
                end
            end else if (i_item.psu_absent) begin
                n_debounce = r_cfg_debounce;
                if (r_tick_en && r_grace == '0) n_tick_en = 1'b0;
            end else begin
                n_grace   = r_cfg_grace;
                n_tick_en = 1'b1;
                if (r_debounce != '0) begin
                    // still debouncing: timekeeping drops again on zero grace
                    if (r_cfg_grace == '0) n_tick_en = 1'b0;
                end else begin
                    n_connect    = '1;
                    n_three_mode = i_item.three_battery_jumper;
                end
            end

            // Relay drive and status follow the phase being entered.
            // Trickle decides on the timer value before any reload; charging2
            // looks at the timer after it.
            case (n_phase)
                PH_CHG1: begin
                    n_relay  = RELAY_BANK1;
                    n_status = ST_BANK1;
                end
                PH_CHG2: begin
                    n_relay  = (n_trickle != '0) ? RELAY_OFF : RELAY_BANK2;
                    n_status = ST_BANK2;
                end
                PH_TRK1: begin
                    n_relay  = (r_trickle > TW'(r_cfg_thresh)) ? RELAY_OFF : RELAY_BANK1;
                    n_status = ST_DONE;
                end
                PH_TRK2: begin
                    n_relay  = (r_trickle > TW'(r_cfg_thresh)) ? RELAY_OFF : RELAY_BANK2;
                    n_status = ST_DONE;
                end
                default: begin
                    n_relay  = RELAY_OFF;
                    n_status = ST_OFF;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result: shows the state after the request
    // ------------------------------------------------------------------
    logic w_rep_act;
    assign w_rep_act = (n_phase != PH_IDLE);

    always_comb begin
        n_out.phase          = n_phase;
        n_out.relay_bank1    = n_relay[0];
        n_out.relay_bank2    = n_relay[1];
        n_out.relay_common   = n_relay[2];
        n_out.status_lines   = n_status;
        n_out.timekeeping_on = n_tick_en;
        n_out.force_reset    = w_forced;
        // connect time is the elapsed count, top three bits of the inverted timer
        n_out.report_flags   = {n_last_absent,
                                w_rep_act ? ~n_connect[TW-1 -: 3] : 3'b000,
                                n_three_mode,
                                w_rep_act ? n_phase : PH_IDLE};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_three_mode  <= 1'b1;
            r_relay       <= RELAY_OFF;
            r_status      <= ST_OFF;
            r_trickle     <= '0;
            r_debounce    <= DEBOUNCE_RESET;
            r_grace       <= '0;
            r_tick_en     <= 1'b0;
            r_done        <= '0;
            r_pend        <= '0;
            r_chg_tmr     <= '{default: '0};
            r_connect     <= '0;
            r_stuck       <= TW'(STUCK_RESET);
            r_last_absent <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_three_mode  <= n_three_mode;
            r_relay       <= n_relay;
            r_status      <= n_status;
            r_trickle     <= n_trickle;
            r_debounce    <= n_debounce;
            r_grace       <= n_grace;
            r_tick_en     <= n_tick_en;
            r_done        <= n_done;
            r_pend        <= n_pend;
            r_chg_tmr     <= n_chg_tmr;
            r_connect     <= n_connect;
            r_stuck       <= n_stuck;
            r_last_absent <= n_last_absent;
            if (w_in_acc)             r_out_valid <= 1'b1;
            else if (o_result.ready)  r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) r_out <= n_out;
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.phase          = r_out.phase;
    assign o_result.relay_bank1    = r_out.relay_bank1;
    assign o_result.relay_bank2    = r_out.relay_bank2;
    assign o_result.relay_common   = r_out.relay_common;
    assign o_result.status_lines   = r_out.status_lines;
    assign o_result.timekeeping_on = r_out.timekeeping_on;
    assign o_result.force_reset    = r_out.force_reset;
    assign o_result.report_flags   = r_out.report_flags;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
`include "dual_bank_charge_sequencer_core_assert.svh"

    `DBCS_ASSERT_NOW(a_forced_is_idle, i_clk, i_rst_n, o_result.valid && o_result.force_reset, (o_result.phase == PH_IDLE) && !o_result.timekeeping_on, "forced reset result not idle")
    `DBCS_ASSERT_NOW(a_stall_blocks_in, i_clk, i_rst_n, r_out_valid && !o_result.ready, !i_item.ready, "request taken while result stalled")
    `DBCS_ASSERT_NEXT(a_dead_tick, i_clk, i_rst_n, w_in_acc && !i_item.kind && !r_tick_en, $stable(r_phase) && $stable(r_stuck), "tick changed state while timekeeping off")
    `DBCS_ASSERT_NOW(a_relay_needs_phase, i_clk, i_rst_n, r_relay != RELAY_OFF, r_phase != PH_IDLE, "relays driven in idle")

endmodule
